/* rtl/ple_pkg.sv */
// ----------------------------------------------------------------------------
// ple_pkg: shared types for the positional list engine
// Command and status codes, word width and the control word that the top
// level broadcasts to every cell of the list.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int WORD_W = 32;
  localparam int POS_W  = 5;
  localparam int CNT_W  = 5;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_CLEAR  = 2'd3
  } ple_cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } ple_status_t;

  // Broadcast to all cells: one committed edit per cycle at most.
  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic [POS_W-1:0]         pos;
    logic signed [WORD_W-1:0] word;
  } ple_cell_ctl_t;

endpackage

/* rtl/ple_if.sv */
// ----------------------------------------------------------------------------
// ple_if: command and response channels of the positional list engine
// Valid/ready channels; a word moves at a clock edge with both high.
// ----------------------------------------------------------------------------
interface ple_cmd_if;
  logic                              valid;
  logic                              ready;
  ple_pkg::ple_cmd_t                 cmd;
  logic [ple_pkg::POS_W-1:0]         position;
  logic signed [ple_pkg::WORD_W-1:0] word_in;

  modport source (output valid, cmd, position, word_in, input ready);
  modport sink   (input valid, cmd, position, word_in, output ready);
endinterface

interface ple_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [ple_pkg::WORD_W-1:0] word_out;
  ple_pkg::ple_status_t              status;
  logic [ple_pkg::CNT_W-1:0]         count;

  modport source (output valid, word_out, status, count, input ready);
  modport sink   (input valid, word_out, status, count, output ready);
endinterface

/* rtl/ple_cell.sv */
// ----------------------------------------------------------------------------
// ple_cell: one entry of the list
// Holds one word; on insert takes the word from the cell below or the new
// word, on remove takes the word from the cell above. Drives its word onto
// the read bus when the position names it.
// ----------------------------------------------------------------------------
module ple_cell #(
  parameter int INDEX = 0
) (
  input  logic                              clk,
  input  ple_pkg::ple_cell_ctl_t            ctl,
  input  logic signed [ple_pkg::WORD_W-1:0] up_data,
  input  logic signed [ple_pkg::WORD_W-1:0] dn_data,
  output logic signed [ple_pkg::WORD_W-1:0] data,
  output logic signed [ple_pkg::WORD_W-1:0] rd_data
);
  import ple_pkg::*;

  localparam int POS_SPAN = 1 << POS_W;

  logic hit;
  logic above;

  // Cells beyond the position field's reach are never addressed directly.
  always_comb begin
    if (INDEX < POS_SPAN) begin
      hit   = (ctl.pos == POS_W'(INDEX));
      above = (POS_W'(INDEX) > ctl.pos);
    end else begin
      hit   = 1'b0;
      above = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ins && hit) begin
      data <= ctl.word;
    end else if (ctl.ins && above) begin
      data <= up_data;
    end else if (ctl.rem && (hit || above)) begin
      data <= dn_data;
    end
  end

  assign rd_data = hit ? data : '0;

endmodule

/* rtl/positional_list_engine.sv */
// ----------------------------------------------------------------------------
// positional_list_engine: bounded ordered list of signed 32-bit words
// Insert, remove, read and clear by position over a chain of entry cells.
// ----------------------------------------------------------------------------
// Each command word yields exactly one response word carrying the removed or
// read word (zero otherwise), a status (ok, position out of range, list full)
// and the entry count after the command, low five bits. A command takes one
// clock cycle: every entry lives in its own cell, and an insert or remove
// moves all cells past the position by one place at the same edge, so the
// next command may be taken in the very next cycle. The response sits in an
// output register; a new command is taken whenever that register is empty
// or is being emptied in the same cycle. The list holds CAPACITY entries;
// positions are five bits, so only the first 32 entries are addressable.
// Entry contents are not reset; only the count and the response valid flag are.
// ----------------------------------------------------------------------------
module positional_list_engine #(
  parameter int CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst,
  ple_cmd_if.sink   request,
  ple_rsp_if.source response
);
  import ple_pkg::*;

  localparam int NCNT_W   = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (NCNT_W > POS_W) ? NCNT_W : POS_W;
  localparam int POS_SPAN = 1 << POS_W;
  localparam int RD_N     = (CAPACITY < POS_SPAN) ? CAPACITY : POS_SPAN;

  logic [NCNT_W-1:0]  entry_count;
  logic [NCNT_W-1:0]  entry_count_next;
  logic               accept;
  ple_cell_ctl_t      ctl;
  ple_status_t        status_next;
  logic signed [WORD_W-1:0] word_next;
  logic signed [WORD_W-1:0] rd_word;
  logic [CMP_W-1:0]   pos_ext;
  logic [CMP_W-1:0]   cnt_ext;
  logic               full;

  logic signed [WORD_W-1:0] cell_data [CAPACITY];
  logic signed [WORD_W-1:0] cell_rd   [CAPACITY];

  // Take a new word whenever the response register is free or draining.
  assign request.ready = !response.valid || response.ready;
  assign accept        = request.valid && request.ready;

  assign pos_ext = CMP_W'(request.position);
  assign cnt_ext = CMP_W'(entry_count);
  assign full    = (entry_count == NCNT_W'(CAPACITY));

  // Gather the addressed entry: at most one cell drives a non-zero word.
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < RD_N; i++) begin
      rd_word = rd_word | cell_rd[i];
    end
  end

  // Decode the command, check the position, and build the cell edit.
  always_comb begin
    ctl.ins          = 1'b0;
    ctl.rem          = 1'b0;
    ctl.pos          = request.position;
    ctl.word         = request.word_in;
    status_next      = ST_OK;
    word_next        = '0;
    entry_count_next = entry_count;
    case (request.cmd)
      CMD_INSERT: begin
        if (pos_ext > cnt_ext) begin
          status_next = ST_RANGE;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          ctl.ins          = accept;
          entry_count_next = entry_count + NCNT_W'(1);
        end
      end
      CMD_REMOVE: begin
        if (pos_ext >= cnt_ext) begin
          status_next = ST_RANGE;
        end else begin
          ctl.rem          = accept;
          word_next        = rd_word;
          entry_count_next = entry_count - NCNT_W'(1);
        end
      end
      CMD_READ: begin
        if (pos_ext >= cnt_ext) begin
          status_next = ST_RANGE;
        end else begin
          word_next = rd_word;
        end
      end
      CMD_CLEAR: begin
        entry_count_next = '0;
      end
      default: begin
        entry_count_next = entry_count;
      end
    endcase
  end

  // The chain: each cell looks at its lower and upper neighbour.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [WORD_W-1:0] up_src;
    logic signed [WORD_W-1:0] dn_src;

    if (g == 0) begin : g_first
      assign up_src = request.word_in;
    end else begin : g_mid_up
      assign up_src = cell_data[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign dn_src = cell_data[g];
    end else begin : g_mid_dn
      assign dn_src = cell_data[g+1];
    end

    ple_cell #(
      .INDEX (g)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .up_data (up_src),
      .dn_data (dn_src),
      .data    (cell_data[g]),
      .rd_data (cell_rd[g])
    );
  end

  // Hold the count; clear it on reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (accept) begin
      entry_count <= entry_count_next;
    end
  end

  // Response register: load on accept, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      response.valid <= 1'b0;
    end else if (accept) begin
      response.valid <= 1'b1;
    end else if (response.ready) begin
      response.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      response.word_out <= word_next;
      response.status   <= status_next;
      response.count    <= CNT_W'(entry_count_next);
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= NCNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    accept && (request.cmd == CMD_CLEAR) |=> entry_count == '0)
    else $error("clear left entries behind");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    response.valid && (response.status == ST_FULL) |-> full)
    else $error("full status with room left");

  a_error_word_zero: assert property (@(posedge clk) disable iff (rst)
    response.valid && (response.status != ST_OK) |-> response.word_out == '0)
    else $error("error response carries a word");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    response.valid && !response.ready |-> !request.ready)
    else $error("command taken while response unclaimed");
`endif

endmodule
